### hw/rtl/lidar_spherical_pixel_projection_core_macros.svh
// Assertion macros shared by the projection core RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef LIDAR_SPHERICAL_PIXEL_PROJECTION_CORE_MACROS_SVH
`define LIDAR_SPHERICAL_PIXEL_PROJECTION_CORE_MACROS_SVH

// Implication in the same cycle.
`define LSP_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lsp assertion failed");

// Implication checked in the cycle after the antecedent.
`define LSP_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lsp assertion failed");

`endif

### hw/rtl/lsp_pkg.sv
// Types and constants of the spherical pixel projection core.
// Depends on nothing; used by every module of the core but lsp_div.
package lsp_pkg;

  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 4096;

  localparam int unsigned NumW = 30;
  localparam int unsigned DenW = 18;
  localparam int unsigned QuoW = 13;

  localparam logic signed [14:0] ElevSat = 15'sd9000;
  localparam logic signed [18:0] FullTurn = 19'sd36000;

  localparam logic [2:0] REG_ELEV_UPPER = 3'd0;
  localparam logic [2:0] REG_ELEV_LOWER = 3'd1;
  localparam logic [2:0] REG_ELEV_STEP  = 3'd2;
  localparam logic [2:0] REG_AZIM_UPPER = 3'd3;
  localparam logic [2:0] REG_AZIM_LOWER = 3'd4;
  localparam logic [2:0] REG_AZIM_STEP  = 3'd5;
  localparam logic [2:0] REG_ROWS       = 3'd6;
  localparam logic [2:0] REG_COLS       = 3'd7;

  typedef struct packed {
    logic signed [14:0] elev_top;
    logic signed [14:0] elev_bot;
    logic [14:0]        elev_span;
    logic [13:0]        elev_step;
    logic [6:0]         rows;
    logic signed [16:0] azim_bot;
    logic [16:0]        azim_span;
    logic [12:0]        cols;
  } cfg_t;

endpackage

### hw/rtl/lsp_cfg.sv
// Configuration registers and the sequential derivation of the image geometry.
// Depends on lsp_pkg.
module lsp_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [16:0]   cfg_data_i,
  output lsp_pkg::cfg_t cfg_o,
  output logic          busy_o
);
  import lsp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIX  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_SIZE = 2'd3;

  logic signed [14:0] eu_q, el_q;
  logic [13:0]        es_q;
  logic signed [16:0] au_q, al_q;
  logic [15:0]        as_q;
  logic [6:0]         rw_q;
  logic [12:0]        cw_q;

  logic [1:0]  state_q, state_d;
  logic [4:0]  cnt_q;
  logic [16:0] en_q, an_q, eq_q, aq_q;
  logic [16:0] er_q, ar_q;
  cfg_t        eff_q;

  logic signed [14:0] et, eb;
  logic signed [16:0] ediff, et2;
  logic signed [16:0] at, ab;
  logic signed [18:0] adiff, at2;
  logic [15:0]        ed, ad;
  logic [17:0]        esh, ash;
  logic [17:0]        elim, alim;
  logic [6:0]         rows_n;
  logic [12:0]        cols_n;

  always_comb begin
    et = (eu_q < el_q) ? el_q : eu_q;
    eb = (eu_q < el_q) ? eu_q : el_q;
    ediff = 17'(et) - 17'(eb);
    et2 = 17'(et);
    if (19'(ediff) == FullTurn) begin
      et2 = 17'(et) - $signed({3'b000, es_q});
      if (et2 < 17'(eb)) begin
        et2 = 17'(eb);
      end
    end
    at = (au_q < al_q) ? al_q : au_q;
    ab = (au_q < al_q) ? au_q : al_q;
    adiff = 19'(at) - 19'(ab);
    at2 = 19'(at);
    if (adiff == FullTurn) begin
      at2 = 19'(at) - $signed({3'b000, as_q});
      if (at2 < 19'(ab)) begin
        at2 = 19'(ab);
      end
    end
    ed = (es_q == '0) ? 16'd1 : {2'b00, es_q};
    ad = (as_q == '0) ? 16'd1 : as_q;
    esh = {er_q[16:0], en_q[16]};
    ash = {ar_q[16:0], an_q[16]};
    elim = 18'(eq_q) + 18'd1;
    alim = 18'(aq_q) + 18'd1;
    rows_n = (18'(rw_q) > elim) ? 7'(elim) : rw_q;
    if (rows_n > 7'(MaxRows)) begin
      rows_n = 7'(MaxRows);
    end
    cols_n = (18'(cw_q) > alim) ? 13'(alim) : cw_q;
    if (cols_n > 13'(MaxCols)) begin
      cols_n = 13'(MaxCols);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  state_d = S_IDLE;
      S_FIX:   state_d = S_DIV;
      S_DIV:   state_d = (cnt_q == 5'd16) ? S_SIZE : S_DIV;
      S_SIZE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = S_FIX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eu_q    <= 15'sd1500;
      el_q    <= -15'sd1600;
      es_q    <= 14'd100;
      au_q    <= 17'sd36000;
      al_q    <= '0;
      as_q    <= 16'd9;
      rw_q    <= 7'd32;
      cw_q    <= 13'd512;
      state_q <= S_IDLE;
      cnt_q   <= '0;
      eff_q   <= '{elev_top: 15'sd1500, elev_bot: -15'sd1600, elev_span: 15'd3100,
                   elev_step: 14'd100, rows: 7'd32, azim_bot: '0,
                   azim_span: 17'd35991, cols: 13'd512};
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ELEV_UPPER: eu_q <= $signed(cfg_data_i[14:0]);
          REG_ELEV_LOWER: el_q <= $signed(cfg_data_i[14:0]);
          REG_ELEV_STEP:  es_q <= cfg_data_i[13:0];
          REG_AZIM_UPPER: au_q <= $signed(cfg_data_i);
          REG_AZIM_LOWER: al_q <= $signed(cfg_data_i);
          REG_AZIM_STEP:  as_q <= cfg_data_i[15:0];
          REG_ROWS:       rw_q <= cfg_data_i[6:0];
          REG_COLS:       cw_q <= cfg_data_i[12:0];
          default:        rw_q <= rw_q;
        endcase
      end
      if (state_q == S_FIX) begin
        eff_q.elev_top  <= 15'(et2);
        eff_q.elev_bot  <= eb;
        eff_q.elev_step <= es_q;
        eff_q.azim_bot  <= ab;
        en_q  <= 17'(et2 - 17'(eb));
        an_q  <= 17'(at2 - 19'(ab));
        er_q  <= '0;
        ar_q  <= '0;
        eq_q  <= '0;
        aq_q  <= '0;
        cnt_q <= '0;
      end
      if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 5'd1;
        en_q  <= {en_q[15:0], 1'b0};
        an_q  <= {an_q[15:0], 1'b0};
        if (esh >= 18'(ed)) begin
          er_q <= 17'(esh - 18'(ed));
          eq_q <= {eq_q[15:0], 1'b1};
        end else begin
          er_q <= esh[16:0];
          eq_q <= {eq_q[15:0], 1'b0};
        end
        if (ash >= 18'(ad)) begin
          ar_q <= 17'(ash - 18'(ad));
          aq_q <= {aq_q[15:0], 1'b1};
        end else begin
          ar_q <= ash[16:0];
          aq_q <= {aq_q[15:0], 1'b0};
        end
      end
      if (state_q == S_SIZE) begin
        eff_q.rows      <= rows_n;
        eff_q.cols      <= cols_n;
        eff_q.elev_span <= 15'(eff_q.elev_top - eff_q.elev_bot);
        eff_q.azim_span <= 17'(at2 - 19'(ab));
      end
    end
  end

  assign cfg_o  = eff_q;
  assign busy_o = (state_q != S_IDLE);

endmodule

### hw/rtl/lsp_front.sv
// Front stages: ring elevation, offsets, scaling products and divider operands.
// Depends on lsp_pkg.
module lsp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         v_i,
  input  logic signed [16:0]           azim_i,
  input  logic [5:0]                   ring_i,
  input  logic [19:0]                  range_i,
  input  logic [15:0]                  inten_i,
  input  lsp_pkg::cfg_t                cfg_i,
  output logic                         v_o,
  output logic [lsp_pkg::NumW-1:0]     row_num_o,
  output logic [lsp_pkg::DenW-1:0]     row_den_o,
  output logic                         row_sat_o,
  output logic [lsp_pkg::NumW-1:0]     col_num_o,
  output logic [lsp_pkg::DenW-1:0]     col_den_o,
  output logic                         col_sat_o,
  output logic signed [14:0]           elev_o,
  output logic [52:0]                  pass_o
);
  import lsp_pkg::*;

  logic [2:0]          v_q;
  logic signed [14:0]  e1_q, e2_q, e3_q;
  logic [52:0]         p1_q, p2_q, p3_q;
  logic signed [22:0]  nr_q;
  logic signed [30:0]  nc_q;
  logic [NumW-1:0]     rnum_q, cnum_q;
  logic [DenW-1:0]     rden_q, cden_q;
  logic                rsat_q, csat_q;

  logic [19:0]         prod;
  logic signed [21:0]  ew;
  logic signed [14:0]  es;
  logic signed [15:0]  offr;
  logic signed [17:0]  offc;
  logic [5:0]          rm1;
  logic [11:0]         cm1;
  logic signed [22:0]  nr;
  logic signed [30:0]  nc;
  logic                zr, zc;
  logic [NumW-1:0]     rnum, cnum;
  logic [DenW-1:0]     rden, cden;

  always_comb begin
    prod = ring_i * cfg_i.elev_step;
    ew   = 22'(cfg_i.elev_top) - $signed({2'b00, prod});
    if (ew < 22'(-ElevSat)) begin
      es = -ElevSat;
    end else if (ew > 22'(ElevSat)) begin
      es = ElevSat;
    end else begin
      es = 15'(ew);
    end
    offr = 16'(e1_q) - 16'(cfg_i.elev_bot);
    offc = 18'($signed(p1_q[16:0])) - 18'(cfg_i.azim_bot);
    rm1  = (cfg_i.rows == '0) ? '0 : 6'(cfg_i.rows - 7'd1);
    cm1  = (cfg_i.cols == '0) ? '0 : 12'(cfg_i.cols - 13'd1);
    nr   = offr * $signed({1'b0, rm1});
    nc   = offc * $signed({1'b0, cm1});
    zr   = (cfg_i.rows == '0) || (cfg_i.elev_span == '0);
    zc   = (cfg_i.cols == '0) || (cfg_i.azim_span == '0);
    rnum = (zr || nr_q < 0) ? '0 : NumW'({nr_q[21:0], 1'b0}) + NumW'(cfg_i.elev_span);
    cnum = (zc || nc_q < 0) ? '0 : NumW'({nc_q[28:0], 1'b0}) + NumW'(cfg_i.azim_span);
    rden = zr ? DenW'(1) : DenW'({cfg_i.elev_span, 1'b0});
    cden = zc ? DenW'(1) : DenW'({cfg_i.azim_span, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q   <= es;
      p1_q   <= {inten_i, range_i, azim_i};
      e2_q   <= e1_q;
      p2_q   <= p1_q;
      nr_q   <= nr;
      nc_q   <= nc;
      e3_q   <= e2_q;
      p3_q   <= p2_q;
      rnum_q <= rnum;
      cnum_q <= cnum;
      rden_q <= rden;
      cden_q <= cden;
      rsat_q <= (NumW + QuoW)'(rnum) >= {rden, QuoW'(0)};
      csat_q <= (NumW + QuoW)'(cnum) >= {cden, QuoW'(0)};
    end
  end

  assign v_o       = v_q[2];
  assign row_num_o = rnum_q;
  assign row_den_o = rden_q;
  assign row_sat_o = rsat_q;
  assign col_num_o = cnum_q;
  assign col_den_o = cden_q;
  assign col_sat_o = csat_q;
  assign elev_o    = e3_q;
  assign pass_o    = p3_q;

endmodule

### hw/rtl/lsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Depends on nothing but its parameters.
module lsp_div #(
  parameter int unsigned NW = 30,
  parameter int unsigned DW = 18,
  parameter int unsigned QW = 13,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          v_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic          sat_i,
  input  logic [TW-1:0] tag_i,
  output logic          v_o,
  output logic [QW-1:0] q_o,
  output logic [TW-1:0] tag_o
);
  localparam int unsigned CW = NW + QW + DW;

  logic          v_q   [QW];
  logic [NW-1:0] r_q   [QW];
  logic [QW-1:0] q_q   [QW];
  logic [DW-1:0] d_q   [QW];
  logic          s_q   [QW];
  logic [TW-1:0] t_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vin, sin;
    logic [NW-1:0] rin, rn;
    logic [QW-1:0] qin, qn;
    logic [DW-1:0] din;
    logic [TW-1:0] tin;
    logic [CW-1:0] trial;

    if (k == 0) begin : g_first
      assign vin = v_i;
      assign rin = num_i;
      assign qin = '0;
      assign din = den_i;
      assign sin = sat_i;
      assign tin = tag_i;
    end else begin : g_next
      assign vin = v_q[k-1];
      assign rin = r_q[k-1];
      assign qin = q_q[k-1];
      assign din = d_q[k-1];
      assign sin = s_q[k-1];
      assign tin = t_q[k-1];
    end

    always_comb begin
      trial = CW'(din) << (QW - 1 - k);
      rn    = rin;
      qn    = qin;
      if (CW'(rin) >= trial) begin
        rn = NW'(CW'(rin) - trial);
        qn[QW-1-k] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= rn;
        q_q[k] <= qn;
        d_q[k] <= din;
        s_q[k] <= sin;
        t_q[k] <= tin;
      end
    end
  end

  assign v_o   = v_q[QW-1];
  assign q_o   = s_q[QW-1] ? '1 : q_q[QW-1];
  assign tag_o = t_q[QW-1];

endmodule

### hw/rtl/lidar_spherical_pixel_projection_core.sv
// Top level of the lidar spherical range-image projection core.
// Depends on lsp_pkg, lsp_cfg, lsp_front, lsp_div and the assertion macros.
//
// Channel  | Direction | Beat contents
// s_axis   | in        | azim_in, ring, range_in, inten_in
// m_axis   | out       | pix_row, pix_col, elev_out, azim_out, range_out, inten_out
// cfg      | in        | register index and write data, no read-back
//
// One beat is accepted per cycle unless m_axis stalls or a derivation runs;
// each beat passes 3 front stages, 13 divider stages and 1 output register.
// Each write rederives the geometry in the fix, divide and size states, during
// which s_axis_tready is low. Reset loads the derived reset geometry at once.
// A stall on m_axis freezes the whole pipeline; nothing is dropped or repeated.
`include "lidar_spherical_pixel_projection_core_macros.svh"

module lidar_spherical_pixel_projection_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // azim_in[16:0], ring[22:17], range_in[42:23], inten_in[58:43]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pix_row[5:0], pix_col[17:6], elev_out[32:18], azim_out[49:33],
  // range_out[69:50], inten_out[85:70]
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);
  import lsp_pkg::*;

  cfg_t              cfg;
  logic              busy;
  logic              adv;
  logic              fv;
  logic [NumW-1:0]   rnum, cnum;
  logic [DenW-1:0]   rden, cden;
  logic              rsat, csat;
  logic signed [14:0] elev;
  logic [52:0]       pass;
  logic              rv, cv;
  logic [QuoW-1:0]   rq, cq;
  logic [14:0]       rtag;
  logic [52:0]       ctag;
  logic [6:0]        rlim;
  logic [12:0]       clim;
  logic [5:0]        row;
  logic [11:0]       col;
  logic              out_v_q;
  logic [87:0]       out_q;

  lsp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .busy_o     (busy)
  );

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv && !busy;

  lsp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .v_i       (s_axis_tvalid && s_axis_tready),
    .azim_i    ($signed(s_axis_tdata[16:0])),
    .ring_i    (s_axis_tdata[22:17]),
    .range_i   (s_axis_tdata[42:23]),
    .inten_i   (s_axis_tdata[58:43]),
    .cfg_i     (cfg),
    .v_o       (fv),
    .row_num_o (rnum),
    .row_den_o (rden),
    .row_sat_o (rsat),
    .col_num_o (cnum),
    .col_den_o (cden),
    .col_sat_o (csat),
    .elev_o    (elev),
    .pass_o    (pass)
  );

  lsp_div #(.NW(NumW), .DW(DenW), .QW(QuoW), .TW(15)) u_row_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .v_i    (fv),
    .num_i  (rnum),
    .den_i  (rden),
    .sat_i  (rsat),
    .tag_i  (elev),
    .v_o    (rv),
    .q_o    (rq),
    .tag_o  (rtag)
  );

  lsp_div #(.NW(NumW), .DW(DenW), .QW(QuoW), .TW(53)) u_col_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .v_i    (fv),
    .num_i  (cnum),
    .den_i  (cden),
    .sat_i  (csat),
    .tag_i  (pass),
    .v_o    (cv),
    .q_o    (cq),
    .tag_o  (ctag)
  );

  always_comb begin
    rlim = (cfg.rows == '0) ? '0 : cfg.rows - 7'd1;
    clim = (cfg.cols == '0) ? '0 : cfg.cols - 13'd1;
    row  = (rq > QuoW'(rlim)) ? 6'(rlim) : 6'(rq);
    col  = (cq > clim) ? 12'(clim) : 12'(cq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= cv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {2'b00, ctag[52:17], ctag[16:0], rtag, col, row};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  `LSP_ASSERT_IMP(a_busy_blocks_input, clk_i, rst_ni, busy, !s_axis_tready)
  `LSP_ASSERT_IMP(a_lanes_aligned, clk_i, rst_ni, 1'b1, rv == cv)
  `LSP_ASSERT_NXT(a_write_starts_derive, clk_i, rst_ni, cfg_we_i, busy)
  `LSP_ASSERT_IMP(a_row_in_image, clk_i, rst_ni, m_axis_tvalid && cfg.rows != '0,
                  7'(m_axis_tdata[5:0]) < cfg.rows)

endmodule

### sim/lidar_spherical_pixel_projection_core_test.sv
// Self-checking testbench of the lidar spherical pixel projection core.
// Drives returns and register writes, predicts every pixel beat and compares it.
// Depends on lsp_pkg and the core RTL only.
`timescale 1ns / 1ps

module lidar_spherical_pixel_projection_core_test;
  import lsp_pkg::*;

  typedef struct {
    logic [5:0]         row;
    logic [11:0]        col;
    logic signed [14:0] elev;
    logic signed [16:0] azim;
    logic [19:0]        rng;
    logic [15:0]        inten;
  } pixel_t;

  class pixel_scoreboard;
    longint up_e, lo_e, st_e, up_a, lo_a, st_a, rows_w, cols_w;
    longint rows, cols, e_top, e_bot, a_top, a_bot;
    pixel_t pending[$];
    int errors;

    function new();
      up_e = 1500; lo_e = -1600; st_e = 100;
      up_a = 36000; lo_a = 0; st_a = 9;
      rows_w = 32; cols_w = 512; errors = 0;
      rederive();
    endfunction

    function void fix_axis(longint up, longint lo, longint st, longint wanted, longint cap,
                           output longint top, output longint bot, output longint size);
      longint t, b, lim;
      t = up; b = lo;
      if (t < b) begin
        t = lo; b = up;
      end
      if (t - b == 36000) begin
        t = t - st;
        if (t < b) t = b;
      end
      lim = (t - b) / (st == 0 ? 1 : st) + 1;
      size = wanted > lim ? lim : wanted;
      if (size > cap) size = cap;
      top = t; bot = b;
    endfunction

    function void rederive();
      fix_axis(up_e, lo_e, st_e, rows_w, MaxRows, e_top, e_bot, rows);
      fix_axis(up_a, lo_a, st_a, cols_w, MaxCols, a_top, a_bot, cols);
    endfunction

    function void write_reg(logic [2:0] idx, logic [16:0] v);
      case (idx)
        REG_ELEV_UPPER: up_e = longint'($signed(v[14:0]));
        REG_ELEV_LOWER: lo_e = longint'($signed(v[14:0]));
        REG_ELEV_STEP:  st_e = longint'(v[13:0]);
        REG_AZIM_UPPER: up_a = longint'($signed(v));
        REG_AZIM_LOWER: lo_a = longint'($signed(v));
        REG_AZIM_STEP:  st_a = longint'(v[15:0]);
        REG_ROWS:       rows_w = longint'(v[6:0]);
        REG_COLS:       cols_w = longint'(v[12:0]);
        default: ;
      endcase
      rederive();
    endfunction

    function longint grid_index(longint off, longint span, longint size);
      longint n, q;
      if (size <= 0 || span <= 0) return 0;
      n = off * (size - 1);
      if (n >= 0) q = (2 * n + span) / (2 * span);
      else q = -((2 * (-n) + span) / (2 * span));
      if (q > size - 1) q = size - 1;
      if (q < 0) q = 0;
      return q;
    endfunction

    function void note_return(logic [58:0] d);
      pixel_t p;
      longint az, el;
      az = longint'($signed(d[16:0]));
      el = e_top - longint'(d[22:17]) * st_e;
      if (el < -9000) el = -9000;
      if (el > 9000) el = 9000;
      p.row = 6'(grid_index(el - e_bot, e_top - e_bot, rows));
      p.col = 12'(grid_index(az - a_bot, a_top - a_bot, cols));
      p.elev = 15'(el);
      p.azim = 17'(az);
      p.rng = d[42:23];
      p.inten = d[58:43];
      pending.push_back(p);
    endfunction

    function void check_pixel(logic [87:0] d);
      pixel_t p;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, d);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (d[5:0] !== p.row) begin
        $display("%0t: pix_row expected %0d actual %0d", $time, p.row, d[5:0]); errors++;
      end
      if (d[17:6] !== p.col) begin
        $display("%0t: pix_col expected %0d actual %0d", $time, p.col, d[17:6]); errors++;
      end
      if (d[32:18] !== p.elev) begin
        $display("%0t: elev_out expected %0d actual %0d", $time, p.elev,
                 $signed(d[32:18])); errors++;
      end
      if (d[49:33] !== p.azim) begin
        $display("%0t: azim_out expected %0d actual %0d", $time, p.azim,
                 $signed(d[49:33])); errors++;
      end
      if (d[69:50] !== p.rng) begin
        $display("%0t: range_out expected %0d actual %0d", $time, p.rng, d[69:50]); errors++;
      end
      if (d[85:70] !== p.inten) begin
        $display("%0t: inten_out expected %0d actual %0d", $time, p.inten, d[85:70]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [87:0] m_axis_tdata;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [16:0] cfg_data_i = '0;

  pixel_scoreboard sb;
  int idle_cycles;
  bit stimulus_done;

  always #1 clk_i = ~clk_i;

  lidar_spherical_pixel_projection_core DUT (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stalls, some phases with none.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = stimulus_done ? 0 : gap_len();
      if (g > 0) begin
        m_axis_tready <= 0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  task automatic send_return(int az, int ring, int rng, int inten, bit with_gaps);
    int g;
    logic [58:0] beat;
    g = with_gaps ? gap_len() : 0;
    beat = {16'(inten), 20'(rng), 6'(ring), 17'(az)};
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {5'b0, beat};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_return(beat);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= 17'(v);
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, 17'(v));
  endtask

  task automatic random_returns(int n);
    int az;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) az = int'($urandom());
      else az = int'($urandom_range(0, 72000)) - 36000;
      send_return(az, int'($urandom()), int'($urandom()), int'($urandom()), 1);
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    stimulus_done = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset geometry, field extremes, rings past the image.
    send_return(0, 0, 0, 0, 0);
    send_return(36000, 63, 20'hFFFFF, 16'hFFFF, 0);
    send_return(-36000, 31, 1, 1, 0);
    send_return(17'h0FFFF, 32, 0, 0, 0);
    send_return(17'h10000, 1, 0, 0, 0);
    send_return(35991, 15, 5, 5, 0);
    send_return(4, 16, 6, 7, 0);
    send_return(5, 30, 6, 7, 0);
    drain();

    // Elevation saturation, swapped limits, zero steps, zero sizes.
    write_reg(REG_ELEV_UPPER, 9000);
    write_reg(REG_ELEV_LOWER, -9000);
    write_reg(REG_ELEV_STEP, 9000);
    write_reg(REG_AZIM_UPPER, -36000);
    write_reg(REG_AZIM_LOWER, 36000);
    write_reg(REG_AZIM_STEP, 36000);
    write_reg(REG_ROWS, 64);
    write_reg(REG_COLS, 4096);
    send_return(36000, 0, 1, 2, 0);
    send_return(-36000, 3, 1, 2, 0);
    send_return(0, 63, 1, 2, 0);
    drain();
    write_reg(REG_ELEV_STEP, 0);
    write_reg(REG_AZIM_STEP, 0);
    write_reg(REG_ROWS, 0);
    write_reg(REG_COLS, 0);
    send_return(100, 2, 3, 4, 0);
    drain();
    write_reg(REG_ELEV_LOWER, 9000);
    write_reg(REG_AZIM_LOWER, -36000);
    write_reg(REG_ROWS, 127);
    write_reg(REG_COLS, 8191);
    write_reg(REG_ELEV_STEP, 16383);
    write_reg(REG_AZIM_STEP, 65535);
    send_return(5, 1, 3, 4, 0);
    send_return(-5, 62, 3, 4, 0);
    drain();
    write_reg(REG_COLS, 0);

    // Random phases over random and extreme geometries.
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_ELEV_UPPER, $urandom_range(0, 18000) - 9000);
      write_reg(REG_ELEV_LOWER, $urandom_range(0, 18000) - 9000);
      write_reg(REG_ELEV_STEP, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 400));
      write_reg(REG_AZIM_UPPER, ph % 3 == 0 ? 36000 : $urandom_range(0, 72000) - 36000);
      write_reg(REG_AZIM_LOWER, ph % 3 == 0 ? 0 : $urandom_range(0, 72000) - 36000);
      write_reg(REG_AZIM_STEP, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 200));
      write_reg(REG_ROWS, $urandom());
      write_reg(REG_COLS, $urandom());
      random_returns(36);
      drain();
    end
    stimulus_done = 1;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### lidar_spherical_pixel_projection_core.f
+incdir+hw/rtl
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_cfg.sv
hw/rtl/lsp_front.sv
hw/rtl/lsp_div.sv
hw/rtl/lidar_spherical_pixel_projection_core.sv
sim/lidar_spherical_pixel_projection_core_test.sv
